/* hw/rtl/srfft_pkg.sv */
// Shared types and constants of the split-radix FFT plan sequencer.
package srfft_pkg;

    // Largest transform exponent and number of stack cells.
    localparam int MAX_SIZE_LOG2 = 16;
    localparam int STACK_DEPTH   = 34;

    // Field widths of one plan entry and of the stack fill count.
    localparam int START_W = 16;
    localparam int LG_W    = 5;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

    // Reset value of the size register.
    localparam logic [LG_W-1:0] SIZE_LOG2_RESET = LG_W'(10);

    // Operation kinds of a plan entry.
    typedef enum logic [1:0] {
        KIND_SPLIT = 2'd0,
        KIND_R4    = 2'd1,
        KIND_R2    = 2'd2
    } t_kind;

    // One plan entry as held in a stack cell.
    typedef struct packed {
        t_kind              kind;
        logic [START_W-1:0] start;
        logic [LG_W-1:0]    lg;
    } t_node;

    // Shift control broadcast to every stack cell.
    typedef struct packed {
        logic push;  // pop one, push three: cell takes its push source
        logic pop;   // pop one, push none: cell takes the neighbor below it
    } t_shift;

endpackage

/* hw/rtl/srfft_if.sv */
// Channel interfaces of the split-radix FFT plan sequencer.

// Request channel: one word asks for the next plan entry.
interface srfft_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// Result channel: one word carries one plan entry.
interface srfft_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [1:0]  op_kind;
    logic [15:0] start_index;
    logic [4:0]  block_log2;
    logic        last;

    modport source (output valid, output valid_res, output op_kind, output start_index,
                    output block_log2, output last, input ready);
    modport sink (input valid, input valid_res, input op_kind, input start_index,
                  input block_log2, input last, output ready);
endinterface

// Configuration channel: one word writes the size exponent.
interface srfft_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] size_log2;

    modport source (output valid, output size_log2, input ready);
    modport sink (input valid, input size_log2, output ready);
endinterface

/* hw/rtl/split_radix_fft_plan_sequencer.sv */
// Top level of the split-radix FFT plan sequencer: stack of cells and result register.
//
//   channel   | direction | word
//   ----------+-----------+-------------------------------------------------
//   i_req     | in        | restart
//   o_res     | out       | valid_res, op_kind, start_index, block_log2, last
//   i_cfg     | in        | size_log2 (always ready)
//
// One request word is taken per cycle unless o_res stalls; its entry appears on o_res
// in the next cycle. The rate is set by the top stack cell: it is popped and expanded
// combinationally, and all cells shift by one or two places at the same edge.
// A new request is taken while the result register is empty or being drained.
// Reset empties the stack and sets the size exponent to ten.
module split_radix_fft_plan_sequencer
    import srfft_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    srfft_req_if.sink    i_req,
    srfft_res_if.source  o_res,
    srfft_cfg_if.sink    i_cfg
);

    logic [LG_W-1:0]  r_size_log2;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_node            r_out_node;
    logic             r_out_hit;
    logic             r_out_last;

    logic             w_accept;
    logic [LG_W-1:0]  w_seed_lg;
    t_node            w_seed;
    t_node            w_top;
    logic             w_nonempty;
    logic             w_has_kids;
    t_node [2:0]      w_child;
    logic [CNT_W:0]   w_sum;
    t_shift           w_ctl;
    t_node            w_cell [STACK_DEPTH];

    // Configuration register, always ready.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_LOG2_RESET;
        end else if (i_cfg.valid) begin
            r_size_log2 <= i_cfg.size_log2;
        end
    end

    // Handshake: take a request when the result register is free.
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Seed entry of a restart, with the exponent saturated.
    assign w_seed_lg = (r_size_log2 > LG_W'(MAX_SIZE_LOG2)) ? LG_W'(MAX_SIZE_LOG2)
                                                             : r_size_log2;
    always_comb begin
        w_seed.start = '0;
        w_seed.lg    = w_seed_lg;
        if (w_seed_lg >= LG_W'(3)) begin
            w_seed.kind = KIND_SPLIT;
        end else if (w_seed_lg == LG_W'(2)) begin
            w_seed.kind = KIND_R4;
        end else begin
            w_seed.kind = KIND_R2;
        end
    end

    // Entry popped this cycle: the seed on restart, else the top cell.
    assign w_top      = i_req.restart ? w_seed : w_cell[0];
    assign w_nonempty = i_req.restart ? (w_seed_lg != '0) : (r_count != '0);

    srfft_expand u_expand (
        .i_node     (w_top),
        .o_has_kids (w_has_kids),
        .o_child    (w_child)
    );

    // Fill count after the pop and any pushes, held at the stack depth.
    assign w_sum = i_req.restart ? (CNT_W+1)'(w_has_kids ? 3 : 0)
                                 : (CNT_W+1)'(r_count) - (CNT_W+1)'(1)
                                   + (CNT_W+1)'(w_has_kids ? 3 : 0);

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (!w_nonempty) begin
                n_count = '0;
            end else if (w_sum > (CNT_W+1)'(STACK_DEPTH)) begin
                n_count = CNT_W'(STACK_DEPTH);
            end else begin
                n_count = w_sum[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Shift control for the chain of cells.
    assign w_ctl.push = w_accept && w_nonempty && w_has_kids;
    assign w_ctl.pop  = w_accept && w_nonempty && !w_has_kids;

    // Chain of stack cells: cell 0 is the top of the stack.
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        t_node w_push_src;
        t_node w_pop_src;

        if (k < 3) begin : g_load
            assign w_push_src = w_child[k];
        end else begin : g_down
            assign w_push_src = w_cell[k-2];
        end

        if (k < STACK_DEPTH - 1) begin : g_up
            assign w_pop_src = w_cell[k+1];
        end else begin : g_bottom
            assign w_pop_src = w_cell[k];
        end

        srfft_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_push_src (w_push_src),
            .i_pop_src  (w_pop_src),
            .o_node     (w_cell[k])
        );
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_node <= w_top;
            r_out_hit  <= w_nonempty;
            r_out_last <= w_nonempty && (n_count == '0);
        end
    end

    // An exhausted plan reads as all zeros.
    assign o_res.valid       = r_out_valid;
    assign o_res.valid_res   = r_out_hit;
    assign o_res.op_kind     = r_out_hit ? r_out_node.kind : 2'd0;
    assign o_res.start_index = r_out_hit ? r_out_node.start : '0;
    assign o_res.block_log2  = r_out_hit ? r_out_node.lg : '0;
    assign o_res.last        = r_out_last;

endmodule

/* hw/rtl/srfft_cell.sv */
// One cell of the shifting plan stack.
module srfft_cell
    import srfft_pkg::*;
(
    input  logic   i_clk,
    input  t_shift i_ctl,
    input  t_node  i_push_src,
    input  t_node  i_pop_src,
    output t_node  o_node
);

    t_node r_node;
    t_node n_node;

    // Select the next entry: a push moves entries down, a pop moves them up.
    always_comb begin
        n_node = r_node;
        if (i_ctl.push) begin
            n_node = i_push_src;
        end else if (i_ctl.pop) begin
            n_node = i_pop_src;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
    end

    assign o_node = r_node;

endmodule

/* hw/rtl/srfft_expand.sv */
// Expansion of a split node into its three children.
module srfft_expand
    import srfft_pkg::*;
(
    input  t_node       i_node,
    output logic        o_has_kids,
    output t_node [2:0] o_child
);

    logic [START_W-1:0] w_half;
    logic [START_W-1:0] w_quarter;

    // Half and quarter block sizes, only meaningful for exponents of five and up.
    assign w_half    = START_W'(1) << (i_node.lg - LG_W'(1));
    assign w_quarter = START_W'(1) << (i_node.lg - LG_W'(2));

    // Only a split of size eight or more has children.
    assign o_has_kids = (i_node.kind == KIND_SPLIT) && (i_node.lg >= LG_W'(3));

    // Child 0 ends up on top of the stack, so it is visited first.
    always_comb begin
        if (i_node.lg >= LG_W'(5)) begin
            o_child[0] = '{kind: KIND_SPLIT, start: i_node.start,
                           lg: i_node.lg - LG_W'(1)};
            o_child[1] = '{kind: KIND_SPLIT, start: i_node.start + w_half,
                           lg: i_node.lg - LG_W'(2)};
            o_child[2] = '{kind: KIND_SPLIT, start: i_node.start + w_half + w_quarter,
                           lg: i_node.lg - LG_W'(2)};
        end else if (i_node.lg == LG_W'(4)) begin
            o_child[0] = '{kind: KIND_SPLIT, start: i_node.start, lg: LG_W'(3)};
            o_child[1] = '{kind: KIND_R4, start: i_node.start + START_W'(8), lg: LG_W'(2)};
            o_child[2] = '{kind: KIND_R4, start: i_node.start + START_W'(12), lg: LG_W'(2)};
        end else begin
            o_child[0] = '{kind: KIND_R4, start: i_node.start, lg: LG_W'(2)};
            o_child[1] = '{kind: KIND_R2, start: i_node.start + START_W'(4), lg: LG_W'(1)};
            o_child[2] = '{kind: KIND_R2, start: i_node.start + START_W'(6), lg: LG_W'(1)};
        end
    end

endmodule

/* tb/tb_split_radix_fft_plan_sequencer.sv */
// Testbench of the split-radix FFT plan sequencer: random plan walks checked against a predictor.
module tb_split_radix_fft_plan_sequencer;
    import srfft_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 1350;

    // One expected plan entry as seen on the result channel.
    typedef struct packed {
        logic               valid_res;
        t_kind              kind;
        logic [START_W-1:0] start;
        logic [LG_W-1:0]    lg;
        logic               last;
    } t_plan_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    srfft_req_if req_ch();
    srfft_res_if res_ch();
    srfft_cfg_if cfg_ch();

    split_radix_fft_plan_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Stimulus and expectation stores.
    logic        request_queue[$];
    t_plan_entry expected_entries[$];

    // Predictor state: pending walk nodes, their count and the size register.
    t_node           pending_nodes[STACK_DEPTH];
    int unsigned     pending_fill = 0;
    logic [LG_W-1:0] size_reg = SIZE_LOG2_RESET;

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int items_queued   = 0;
    bit req_taken      = 1'b0;

    // Clock with a period of ten.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_pending(input t_kind k, input int unsigned s,
                                         input int unsigned lg);
        if (pending_fill < STACK_DEPTH) begin
            pending_nodes[pending_fill] = '{kind: k, start: START_W'(s), lg: LG_W'(lg)};
            pending_fill++;
        end
    endfunction

    // Pops the next node of the pre-order walk and pushes its children, first child on top.
    function automatic t_plan_entry next_plan_entry(input logic restart);
        t_plan_entry e;
        t_node       cur;
        int unsigned n;
        int unsigned s;
        e = '0;
        if (restart) begin
            n = (size_reg > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : size_reg;
            pending_fill = 0;
            if (n >= 3) push_pending(KIND_SPLIT, 0, n);
            else if (n == 2) push_pending(KIND_R4, 0, 2);
            else if (n == 1) push_pending(KIND_R2, 0, 1);
        end
        if (pending_fill == 0) return e;
        pending_fill--;
        cur = pending_nodes[pending_fill];
        s = cur.start;
        if (cur.kind == KIND_SPLIT) begin
            if (cur.lg >= 5) begin
                push_pending(KIND_SPLIT, s + 3 * (1 << (cur.lg - 2)), cur.lg - 2);
                push_pending(KIND_SPLIT, s + (1 << (cur.lg - 1)), cur.lg - 2);
                push_pending(KIND_SPLIT, s, cur.lg - 1);
            end else if (cur.lg == 4) begin
                push_pending(KIND_R4, s + 12, 2);
                push_pending(KIND_R4, s + 8, 2);
                push_pending(KIND_SPLIT, s, 3);
            end else if (cur.lg == 3) begin
                push_pending(KIND_R2, s + 6, 1);
                push_pending(KIND_R2, s + 4, 1);
                push_pending(KIND_R4, s, 2);
            end
        end
        e.valid_res = 1'b1;
        e.kind      = cur.kind;
        e.start     = cur.start;
        e.lg        = cur.lg;
        e.last      = (pending_fill == 0);
        return e;
    endfunction

    // Number of entries in a full plan of the given size exponent.
    function automatic int plan_length(input int n);
        int len[0:MAX_SIZE_LOG2];
        if (n > MAX_SIZE_LOG2) n = MAX_SIZE_LOG2;
        len[0] = 0;
        len[1] = 1;
        len[2] = 1;
        for (int k = 3; k <= MAX_SIZE_LOG2; k++) len[k] = 1 + len[k - 1] + 2 * len[k - 2];
        return len[n];
    endfunction

    // Queues one restart (or continuation) word followed by a number of next-entry words.
    task automatic queue_walk(input logic first, input int more);
        request_queue.push_back(first);
        repeat (more) request_queue.push_back(1'b0);
        items_queued += more + 1;
    endtask

    // Blocks until every queued word was taken and every expected word has come back.
    task automatic wait_drained();
        while (request_queue.size() != 0 || req_ch.valid || expected_entries.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes the size register once the block is idle.
    task automatic write_size(input logic [LG_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.size_log2 <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        size_reg = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Request driver: holds a word until taken, then offers the next one or idles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_ch.valid   <= 1'b1;
                req_ch.restart <= request_queue.pop_front();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Accepted requests feed the predictor.
    always @(posedge i_clk) begin
        req_taken = i_rst_n && req_ch.valid && req_ch.ready;
        if (req_taken) expected_entries.push_back(next_plan_entry(req_ch.restart));
    end

    // Result monitor: each accepted word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_plan_entry want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_entries.size() == 0) begin
                report_mismatch("result with no request waiting", res_ch.start_index, 0);
            end else begin
                want = expected_entries.pop_front();
                if (res_ch.valid_res !== want.valid_res)
                    report_mismatch("valid_res", res_ch.valid_res, want.valid_res);
                if (res_ch.op_kind !== want.kind)
                    report_mismatch("op_kind", res_ch.op_kind, want.kind);
                if (res_ch.start_index !== want.start)
                    report_mismatch("start_index", res_ch.start_index, want.start);
                if (res_ch.block_log2 !== want.lg)
                    report_mismatch("block_log2", res_ch.block_log2, want.lg);
                if (res_ch.last !== want.last)
                    report_mismatch("last", res_ch.last, want.last);
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed cases, then random phases of plan walks.
    initial begin
        int phase;
        int sz;
        int r;
        int len;
        int phase_items;
        req_ch.valid     = 1'b0;
        req_ch.restart   = 1'b0;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.size_log2 = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A request before any restart finds an exhausted plan; then the reset size.
        request_queue.push_back(1'b0);
        items_queued++;
        queue_walk(1'b1, 3);
        // Empty plan, single radix-2 leaf past its end, single radix-4 leaf.
        write_size(5'd0);
        queue_walk(1'b1, 0);
        write_size(5'd1);
        queue_walk(1'b1, 1);
        write_size(5'd2);
        queue_walk(1'b1, 0);
        // Smallest split tree walked past its end.
        write_size(5'd3);
        queue_walk(1'b1, 4);
        // Oversized exponent saturates to the largest size.
        write_size(5'd31);
        queue_walk(1'b1, 2);
        // A new size does not touch the plan in progress until the next restart.
        write_size(5'd4);
        queue_walk(1'b0, 1);
        queue_walk(1'b1, 6);

        phase = 0;
        while (items_queued < TARGET_ITEMS) begin
            r = $urandom_range(99);
            if (r < 55) sz = $urandom_range(7);
            else if (r < 70) sz = $urandom_range(9, 8);
            else if (r < 90) sz = $urandom_range(16, 10);
            else sz = $urandom_range(31, 17);
            // The register is written only with the block drained, so the sender pauses here.
            write_size(5'(sz));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            phase_items = 0;
            // Sometimes carry on with the plan started under the old size.
            if ($urandom_range(99) < 30) begin
                queue_walk(1'b0, $urandom_range(4));
                phase_items += 1;
            end
            len = plan_length(sz);
            while (phase_items < 80) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    queue_walk(1'b0, 0);
                    phase_items += 1;
                end else if (r < 75 && len <= 80) begin
                    // Full walk, sometimes past the final entry.
                    queue_walk(1'b1, (len > 0 ? len - 1 : 0) + $urandom_range(2));
                    phase_items += len + 1;
                end else begin
                    // Walk cut short by the next restart.
                    r = $urandom_range(len < 40 ? len : 40);
                    queue_walk(1'b1, r);
                    phase_items += r + 1;
                end
            end
            phase++;
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (expected_entries.size() != 0)
            report_mismatch("results never delivered", 0, expected_entries.size());
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
